// ===== rtl/amrc_pkg.sv =====
package amrc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int MS_W          = 16;
    localparam int WIDE_W        = 64;
    localparam int ACC_W         = 66;
    localparam int CFG_IDX_W     = 3;
    localparam int PC_W          = 6;
    localparam int SLOT_N        = 32;
    localparam int MS_DIV        = 1000;

    typedef struct packed {
        logic signed [WORD_W-1:0] plant_output;
        logic        [MS_W-1:0]   elapsed_ms;
    } in_word_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] drive;
        logic signed [WORD_W-1:0] normalized_error;
        logic signed [WORD_W-1:0] model_output;
    } out_word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODEL_POLE,
        REG_ADAPT_GAIN,
        REG_FILTER_POLE,
        REG_MODEL_GAIN,
        REG_REF_LEVEL
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_RUN,
        FS_MULW,
        FS_DIVW
    } fsm_t;

    typedef enum logic [3:0] {
        K_CLR,
        K_ONE,
        K_MAC,
        K_ADD,
        K_STO,
        K_STE,
        K_DIV,
        K_INT,
        K_FIN
    } kind_t;

    typedef enum logic [4:0] {
        SL_G0, SL_G1, SL_G2, SL_G3,
        SL_X0, SL_X1, SL_X2, SL_X3,
        SL_W0, SL_W1, SL_Z, SL_YM,
        SL_UOLD, SL_YP,
        SL_AM, SL_GAM, SL_LAM, SL_KM, SL_R,
        SL_UNEW, SL_NUM, SL_ERR, SL_GE
    } slot_t;

    typedef struct packed {
        kind_t kind;
        slot_t sa;
        slot_t sb;
        logic  neg;
    } step_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (x > hi)
            return 32'sh7fffffff;
        else if (x < lo)
            return 32'sh80000000;
        return x[WORD_W-1:0];
    endfunction

    function automatic step_t mk(input kind_t k, input slot_t a, input slot_t b, input logic n);
        step_t s;
        s.kind = k;
        s.sa   = a;
        s.sb   = b;
        s.neg  = n;
        return s;
    endfunction

    // microcode for one control step
    function automatic step_t step_rom(input logic [PC_W-1:0] pc);
        step_t s;
        unique case (pc)
            6'd0:  s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd1:  s = mk(K_MAC, SL_G0, SL_W0, 1'b0);
            6'd2:  s = mk(K_MAC, SL_G1, SL_W1, 1'b0);
            6'd3:  s = mk(K_MAC, SL_G2, SL_YP, 1'b0);
            6'd4:  s = mk(K_MAC, SL_G3, SL_R, 1'b0);
            6'd5:  s = mk(K_STO, SL_UNEW, SL_G0, 1'b0);
            6'd6:  s = mk(K_ONE, SL_G0, SL_G0, 1'b0);
            6'd7:  s = mk(K_MAC, SL_X0, SL_X0, 1'b0);
            6'd8:  s = mk(K_MAC, SL_X1, SL_X1, 1'b0);
            6'd9:  s = mk(K_MAC, SL_X2, SL_X2, 1'b0);
            6'd10: s = mk(K_MAC, SL_X3, SL_X3, 1'b0);
            6'd11: s = mk(K_STE, SL_G0, SL_G0, 1'b0);
            6'd12: s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd13: s = mk(K_ADD, SL_Z, SL_G0, 1'b0);
            6'd14: s = mk(K_MAC, SL_G0, SL_X0, 1'b1);
            6'd15: s = mk(K_MAC, SL_G1, SL_X1, 1'b1);
            6'd16: s = mk(K_MAC, SL_G2, SL_X2, 1'b1);
            6'd17: s = mk(K_MAC, SL_G3, SL_X3, 1'b1);
            6'd18: s = mk(K_STO, SL_NUM, SL_G0, 1'b0);
            6'd19: s = mk(K_DIV, SL_ERR, SL_G0, 1'b0);
            6'd20: s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd21: s = mk(K_MAC, SL_GAM, SL_ERR, 1'b0);
            6'd22: s = mk(K_STO, SL_GE, SL_G0, 1'b0);
            6'd23: s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd24: s = mk(K_MAC, SL_GE, SL_X0, 1'b0);
            6'd25: s = mk(K_INT, SL_G0, SL_G0, 1'b0);
            6'd26: s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd27: s = mk(K_MAC, SL_GE, SL_X1, 1'b0);
            6'd28: s = mk(K_INT, SL_G1, SL_G0, 1'b0);
            6'd29: s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd30: s = mk(K_MAC, SL_GE, SL_X2, 1'b0);
            6'd31: s = mk(K_INT, SL_G2, SL_G0, 1'b0);
            6'd32: s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd33: s = mk(K_MAC, SL_GE, SL_X3, 1'b0);
            6'd34: s = mk(K_INT, SL_G3, SL_G0, 1'b0);
            6'd35: s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd36: s = mk(K_MAC, SL_KM, SL_W0, 1'b0);
            6'd37: s = mk(K_MAC, SL_AM, SL_X0, 1'b1);
            6'd38: s = mk(K_INT, SL_X0, SL_G0, 1'b0);
            6'd39: s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd40: s = mk(K_MAC, SL_KM, SL_W1, 1'b0);
            6'd41: s = mk(K_MAC, SL_AM, SL_X1, 1'b1);
            6'd42: s = mk(K_INT, SL_X1, SL_G0, 1'b0);
            6'd43: s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd44: s = mk(K_MAC, SL_KM, SL_YP, 1'b0);
            6'd45: s = mk(K_MAC, SL_AM, SL_X2, 1'b1);
            6'd46: s = mk(K_INT, SL_X2, SL_G0, 1'b0);
            6'd47: s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd48: s = mk(K_ADD, SL_UOLD, SL_G0, 1'b0);
            6'd49: s = mk(K_MAC, SL_LAM, SL_W0, 1'b1);
            6'd50: s = mk(K_INT, SL_W0, SL_G0, 1'b0);
            6'd51: s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd52: s = mk(K_ADD, SL_YP, SL_G0, 1'b0);
            6'd53: s = mk(K_MAC, SL_LAM, SL_W1, 1'b1);
            6'd54: s = mk(K_INT, SL_W1, SL_G0, 1'b0);
            6'd55: s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd56: s = mk(K_MAC, SL_KM, SL_UOLD, 1'b0);
            6'd57: s = mk(K_MAC, SL_AM, SL_Z, 1'b1);
            6'd58: s = mk(K_INT, SL_Z, SL_G0, 1'b0);
            6'd59: s = mk(K_CLR, SL_G0, SL_G0, 1'b0);
            6'd60: s = mk(K_MAC, SL_KM, SL_R, 1'b0);
            6'd61: s = mk(K_MAC, SL_AM, SL_YM, 1'b1);
            6'd62: s = mk(K_INT, SL_YM, SL_G0, 1'b0);
            6'd63: s = mk(K_FIN, SL_G0, SL_G0, 1'b0);
            default: s = mk(K_FIN, SL_G0, SL_G0, 1'b0);
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/adaptive_model_reference_controller_core.sv =====
// Gradient-law model reference adaptive controller in signed fixed point with
// FRAC_BITS fraction bits. One input word (plant output and elapsed
// milliseconds) yields one output word (drive, normalized error, model output).
// Items are processed one at a time. A 64-step microcode sequence drives one
// shared bit-serial multiplier (32 x 32 bits) and one shared bit-serial
// divider (64-bit quotient). Each word takes 29 products and 11 state
// integrations (product by the elapsed time, then division by 1000), one error
// division and the clear, load, add and store steps between them; the result
// is then handed to the output register. A new word is accepted only once the
// sequence has finished and handed its result over. in_ready is high while the
// sequencer is idle; a finished result waits in the output register while the
// next word is accepted.
module adaptive_model_reference_controller_core
    import amrc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_word_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_word_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata
);

    localparam logic signed [WORD_W-1:0] OneQ      = WORD_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [63:0]       RefRaw    = -64'sd10 * (64'sd1 <<< FRAC_BITS);
    localparam logic signed [WORD_W-1:0] RefReset  =
        (RefRaw < -64'sd2147483648) ? 32'sh80000000 : RefRaw[WORD_W-1:0];
    localparam logic signed [ACC_W-1:0]  OneAcc    = ACC_W'(66'sd1 <<< FRAC_BITS);
    localparam logic signed [63:0]       RndHalf   = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic [WIDE_W-1:0]        MsDiv     = WIDE_W'(MS_DIV);
    localparam logic [WIDE_W-1:0]        MsHalf    = WIDE_W'(MS_DIV / 2);

    fsm_t state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [WIDE_W-1:0] energy_reg;
    logic energy_we;
    logic dsign_reg;

    logic signed [WORD_W-1:0] am_reg, gam_reg, lam_reg, km_reg, r_reg;
    logic signed [WORD_W-1:0] g0_reg, g1_reg, g2_reg, g3_reg;
    logic signed [WORD_W-1:0] x0_reg, x1_reg, x2_reg, x3_reg;
    logic signed [WORD_W-1:0] w0_reg, w1_reg, z_reg, ym_reg, uold_reg;
    logic signed [WORD_W-1:0] unew_reg, num_reg, err_reg, ge_reg;
    logic signed [WORD_W-1:0] yp_reg;
    logic [MS_W-1:0] ms_reg;

    logic out_valid_reg;
    out_word_t out_reg;

    step_t st;
    logic signed [WORD_W-1:0] slot_val [SLOT_N];
    logic signed [WORD_W-1:0] opa, opb;

    logic mul_start, mul_done;
    logic signed [WORD_W-1:0] mul_a, mul_b;
    logic signed [2*WORD_W-1:0] mul_p;
    logic signed [63:0] mul_rnd;
    logic [WIDE_W-1:0] p_mag;

    logic div_start, div_done;
    logic [WIDE_W-1:0] div_dvd, div_dvs, div_q;
    logic [WORD_W:0] num_mag;
    logic signed [ACC_W-1:0] q_s;

    logic wr_en;
    slot_t wr_slot;
    logic signed [WORD_W-1:0] wr_val;
    logic fin_take;

    assign st = step_rom(pc_reg);

    always_comb
    begin
        for (int i = 0; i < SLOT_N; i++)
            slot_val[i] = '0;
        slot_val[SL_G0]   = g0_reg;
        slot_val[SL_G1]   = g1_reg;
        slot_val[SL_G2]   = g2_reg;
        slot_val[SL_G3]   = g3_reg;
        slot_val[SL_X0]   = x0_reg;
        slot_val[SL_X1]   = x1_reg;
        slot_val[SL_X2]   = x2_reg;
        slot_val[SL_X3]   = x3_reg;
        slot_val[SL_W0]   = w0_reg;
        slot_val[SL_W1]   = w1_reg;
        slot_val[SL_Z]    = z_reg;
        slot_val[SL_YM]   = ym_reg;
        slot_val[SL_UOLD] = uold_reg;
        slot_val[SL_YP]   = yp_reg;
        slot_val[SL_AM]   = am_reg;
        slot_val[SL_GAM]  = gam_reg;
        slot_val[SL_LAM]  = lam_reg;
        slot_val[SL_KM]   = km_reg;
        slot_val[SL_R]    = r_reg;
        slot_val[SL_UNEW] = unew_reg;
        slot_val[SL_NUM]  = num_reg;
        slot_val[SL_ERR]  = err_reg;
        slot_val[SL_GE]   = ge_reg;
    end

    assign opa = slot_val[st.sa];
    assign opb = slot_val[st.sb];

    assign mul_a   = (st.kind == K_INT) ? sat32(acc_reg) : opa;
    assign mul_b   = (st.kind == K_INT) ? $signed({{(WORD_W-MS_W){1'b0}}, ms_reg}) : opb;
    assign mul_rnd = (mul_p + RndHalf) >>> FRAC_BITS;
    assign p_mag   = mul_p[2*WORD_W-1] ? WIDE_W'(-mul_p) : WIDE_W'(mul_p);

    assign num_mag = num_reg[WORD_W-1] ? (33'd0 - {1'b1, num_reg}) : {1'b0, num_reg};
    assign div_dvd = (st.kind == K_INT) ? (p_mag + MsHalf)
                                        : ((WIDE_W'(num_mag) << FRAC_BITS) + (energy_reg >> 1));
    assign div_dvs = (st.kind == K_INT) ? MsDiv : energy_reg;
    assign q_s     = dsign_reg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});

    amrc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    amrc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        acc_next   = acc_reg;
        energy_we  = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        wr_en      = 1'b0;
        wr_slot    = st.sa;
        wr_val     = sat32(acc_reg);
        fin_take   = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            FS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    pc_next    = '0;
                    state_next = FS_RUN;
                end
            end
            FS_RUN:
            begin
                unique case (st.kind)
                    K_CLR:
                    begin
                        acc_next = '0;
                        pc_next  = pc_reg + 1'b1;
                    end
                    K_ONE:
                    begin
                        acc_next = OneAcc;
                        pc_next  = pc_reg + 1'b1;
                    end
                    K_ADD:
                    begin
                        acc_next = st.neg ? acc_reg - ACC_W'(opa) : acc_reg + ACC_W'(opa);
                        pc_next  = pc_reg + 1'b1;
                    end
                    K_MAC, K_INT:
                    begin
                        mul_start  = 1'b1;
                        state_next = FS_MULW;
                    end
                    K_STO:
                    begin
                        wr_en   = 1'b1;
                        pc_next = pc_reg + 1'b1;
                    end
                    K_STE:
                    begin
                        energy_we = 1'b1;
                        pc_next   = pc_reg + 1'b1;
                    end
                    K_DIV:
                    begin
                        div_start  = 1'b1;
                        state_next = FS_DIVW;
                    end
                    K_FIN:
                    begin
                        // hold until the output register is free
                        if (!out_valid_reg || out_ready)
                        begin
                            fin_take   = 1'b1;
                            pc_next    = '0;
                            state_next = FS_IDLE;
                        end
                    end
                    default:
                    begin
                        pc_next    = '0;
                        state_next = FS_IDLE;
                    end
                endcase
            end
            FS_MULW:
            begin
                if (mul_done)
                begin
                    if (st.kind == K_INT)
                    begin
                        div_start  = 1'b1;
                        state_next = FS_DIVW;
                    end
                    else
                    begin
                        acc_next   = st.neg ? acc_reg - ACC_W'(mul_rnd)
                                            : acc_reg + ACC_W'(mul_rnd);
                        pc_next    = pc_reg + 1'b1;
                        state_next = FS_RUN;
                    end
                end
            end
            FS_DIVW:
            begin
                if (div_done)
                begin
                    wr_en      = 1'b1;
                    wr_val     = (st.kind == K_INT) ? sat32(ACC_W'(opa) + q_s) : sat32(q_s);
                    pc_next    = pc_reg + 1'b1;
                    state_next = FS_RUN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FS_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (fin_take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            am_reg  <= OneQ;
            gam_reg <= OneQ;
            lam_reg <= OneQ;
            km_reg  <= OneQ;
            r_reg   <= RefReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MODEL_POLE:  am_reg  <= cfg_wdata;
                REG_ADAPT_GAIN:  gam_reg <= cfg_wdata;
                REG_FILTER_POLE: lam_reg <= cfg_wdata;
                REG_MODEL_GAIN:  km_reg  <= cfg_wdata;
                REG_REF_LEVEL:   r_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g0_reg   <= '0;
            g1_reg   <= '0;
            g2_reg   <= '0;
            g3_reg   <= '0;
            x0_reg   <= '0;
            x1_reg   <= '0;
            x2_reg   <= '0;
            x3_reg   <= '0;
            w0_reg   <= '0;
            w1_reg   <= '0;
            z_reg    <= '0;
            ym_reg   <= '0;
            uold_reg <= '0;
            unew_reg <= '0;
            num_reg  <= '0;
            err_reg  <= '0;
            ge_reg   <= '0;
        end
        else if (fin_take)
        begin
            x3_reg   <= yp_reg;
            uold_reg <= unew_reg;
        end
        else if (wr_en)
        begin
            unique case (wr_slot)
                SL_G0:   g0_reg   <= wr_val;
                SL_G1:   g1_reg   <= wr_val;
                SL_G2:   g2_reg   <= wr_val;
                SL_G3:   g3_reg   <= wr_val;
                SL_X0:   x0_reg   <= wr_val;
                SL_X1:   x1_reg   <= wr_val;
                SL_X2:   x2_reg   <= wr_val;
                SL_W0:   w0_reg   <= wr_val;
                SL_W1:   w1_reg   <= wr_val;
                SL_Z:    z_reg    <= wr_val;
                SL_YM:   ym_reg   <= wr_val;
                SL_UNEW: unew_reg <= wr_val;
                SL_NUM:  num_reg  <= wr_val;
                SL_ERR:  err_reg  <= wr_val;
                SL_GE:   ge_reg   <= wr_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (energy_we)
            energy_reg <= acc_reg[WIDE_W-1:0];
        if (div_start)
            dsign_reg <= (st.kind == K_INT) ? mul_p[2*WORD_W-1] : num_reg[WORD_W-1];
        if (in_valid && in_ready)
        begin
            yp_reg <= in_data.plant_output;
            ms_reg <= in_data.elapsed_ms;
        end
        if (fin_take)
        begin
            out_reg.drive            <= unew_reg;
            out_reg.normalized_error <= err_reg;
            out_reg.model_output     <= ym_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/amrc_mul.sv =====
module amrc_mul
    import amrc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [WORD_W-1:0]   a,
    input  logic signed [WORD_W-1:0]   b,
    output logic                       done,
    output logic signed [2*WORD_W-1:0] product
);

    localparam int CntW = $clog2(WORD_W);

    logic [WORD_W-1:0]   ma_reg;
    logic [2*WORD_W-1:0] p_reg;
    logic [2*WORD_W-1:0] p_next;
    logic [WORD_W:0]     sum;
    logic                neg_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [CntW-1:0]     cnt_reg;

    assign sum     = {1'b0, p_reg[2*WORD_W-1:WORD_W]} + (p_reg[0] ? {1'b0, ma_reg} : '0);
    assign p_next  = {sum, p_reg[WORD_W-1:1]};
    assign done    = done_reg;
    assign product = neg_reg ? -$signed(p_reg) : $signed(p_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
            p_reg   <= {{WORD_W{1'b0}}, (b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b))};
            neg_reg <= a[WORD_W-1] ^ b[WORD_W-1];
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
        end
    end

endmodule

// ===== rtl/amrc_div.sv =====
module amrc_div
    import amrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WIDE_W-1:0] dividend,
    input  logic [WIDE_W-1:0] divisor,
    output logic              done,
    output logic [WIDE_W-1:0] quotient
);

    localparam int CntW = $clog2(WIDE_W);

    logic [WIDE_W-1:0] rem_reg;
    logic [WIDE_W-1:0] quo_reg;
    logic [WIDE_W-1:0] dvs_reg;
    logic [WIDE_W:0]   trial;
    logic              fits;
    logic              busy_reg;
    logic              done_reg;
    logic [CntW-1:0]   cnt_reg;

    assign trial    = {rem_reg, quo_reg[WIDE_W-1]} - {1'b0, dvs_reg};
    assign fits     = !trial[WIDE_W];
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(WIDE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[WIDE_W-1:0] : {rem_reg[WIDE_W-2:0], quo_reg[WIDE_W-1]};
            quo_reg <= {quo_reg[WIDE_W-2:0], fits};
        end
    end

endmodule

// ===== rtl/amrc_checker.sv =====
module amrc_checker
    import amrc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // drop ready once a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in progress");

    // no result appears right after a word is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind adaptive_model_reference_controller_core amrc_checker u_amrc_checker (.*);
